// File: design/ffp_pkg.sv
package ffp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       field_start;
   } ffp_req_type;

   typedef struct packed {
      logic [7:0] window_size;
      logic       window_seen;
      logic [7:0] packet_size;
      logic       packet_seen;
      logic [7:0] throughput;
      logic       throughput_seen;
      logic       reverse_charge;
      logic       stopped_early;
      logic       truncated;
   } ffp_rsp_type;

   localparam int unsigned CSR_INDEX_W = 3;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             data;
   } ffp_csr_type;

   typedef struct packed {
      logic [7:0] window_code;
      logic [7:0] packet_code;
      logic [7:0] throughput_code;
      logic [7:0] charge_code;
      logic [7:0] priority_packet_size;
   } ffp_cfg_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_CODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PACKET_CODE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THROUGHPUT_CODE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_CODE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIORITY_SIZE   = 3'd4;

   localparam logic [7:0] RESET_WINDOW_CODE     = 8'd67;
   localparam logic [7:0] RESET_PACKET_CODE     = 8'd66;
   localparam logic [7:0] RESET_THROUGHPUT_CODE = 8'd2;
   localparam logic [7:0] RESET_CHARGE_CODE     = 8'd1;
   localparam logic [7:0] RESET_PRIORITY_SIZE   = 8'd7;

   localparam logic [7:0] STOP_CODE_LOW  = 8'h00;
   localparam logic [7:0] STOP_CODE_HIGH = 8'hFF;

   localparam logic [1:0] CLASS_SKIP_ONE   = 2'd0;
   localparam logic [1:0] CLASS_SKIP_TWO   = 2'd1;
   localparam logic [1:0] CLASS_SKIP_THREE = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_SCAN = 3'b010,
      PH_DONE = 3'b100
   } ffp_phase_type;

   typedef enum logic [5:0] {
      PK_NONE    = 6'b000001,
      PK_WINDOW  = 6'b000010,
      PK_PACKET  = 6'b000100,
      PK_THRU    = 6'b001000,
      PK_CHARGE  = 6'b010000,
      PK_SKIPLEN = 6'b100000
   } ffp_pend_type;

endpackage

// File: design/ffp_chan_if.sv
interface ffp_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/ffp_csr_regs.sv
module ffp_csr_regs import ffp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ffp_chan_if.sink    csr_chan,
   output ffp_cfg_type cfg
);

   ffp_cfg_type cfg_ff;
   ffp_cfg_type cfg_in;
   logic        csr_fire;
   ffp_csr_type csr_word;

   assign csr_chan.ready = 1'b1;
   assign csr_word = csr_chan.payload;
   assign csr_fire = csr_chan.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         unique case (csr_word.index)
            CSR_WINDOW_CODE:     cfg_in.window_code = csr_word.data;
            CSR_PACKET_CODE:     cfg_in.packet_code = csr_word.data;
            CSR_THROUGHPUT_CODE: cfg_in.throughput_code = csr_word.data;
            CSR_CHARGE_CODE:     cfg_in.charge_code = csr_word.data;
            CSR_PRIORITY_SIZE:   cfg_in.priority_packet_size = csr_word.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_code          <= RESET_WINDOW_CODE;
         cfg_ff.packet_code          <= RESET_PACKET_CODE;
         cfg_ff.throughput_code      <= RESET_THROUGHPUT_CODE;
         cfg_ff.charge_code          <= RESET_CHARGE_CODE;
         cfg_ff.priority_packet_size <= RESET_PRIORITY_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/ffp_parse_core.sv
module ffp_parse_core import ffp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ffp_cfg_type cfg,
   ffp_chan_if.sink    req_chan,
   ffp_chan_if.source  rsp_chan
);

   logic          in_valid_ff, in_valid_in;
   ffp_req_type   in_item_ff;
   logic          req_fire;
   logic          out_free;
   logic          fire;

   ffp_phase_type phase_ff, phase_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    pos_ff, pos_in;
   logic [8:0]    ncp_ff, ncp_in;
   ffp_pend_type  pend_ff, pend_in;
   logic [7:0]    win_ff, win_in;
   logic [7:0]    pkt_ff, pkt_in;
   logic [7:0]    thru_ff, thru_in;
   logic          win_seen_ff, win_seen_in;
   logic          pkt_seen_ff, pkt_seen_in;
   logic          thru_seen_ff, thru_seen_in;
   logic          rev_ff, rev_in;
   logic          stop_ff, stop_in;
   logic          trunc_ff, trunc_in;

   logic          emit;
   logic          stop_hit;
   logic [7:0]    b;
   logic [7:0]    pos1;
   logic [8:0]    pos1_ext;

   logic          rsp_valid_ff, rsp_valid_in;
   ffp_rsp_type   rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign fire = in_valid_ff && out_free;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (out_free) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign b = in_item_ff.data_byte;
   assign pos1 = pos_ff + 8'd1;
   assign pos1_ext = {1'b0, pos1};

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      ncp_in       = ncp_ff;
      pend_in      = pend_ff;
      win_in       = win_ff;
      pkt_in       = pkt_ff;
      thru_in      = thru_ff;
      win_seen_in  = win_seen_ff;
      pkt_seen_in  = pkt_seen_ff;
      thru_seen_in = thru_seen_ff;
      rev_in       = rev_ff;
      stop_in      = stop_ff;
      trunc_in     = trunc_ff;
      emit         = 1'b0;
      stop_hit     = 1'b0;
      if (in_item_ff.field_start) begin
         len_in       = b;
         pos_in       = 8'd0;
         ncp_in       = 9'd1;
         pend_in      = PK_NONE;
         win_in       = 8'd0;
         pkt_in       = 8'd0;
         thru_in      = 8'd0;
         win_seen_in  = 1'b0;
         pkt_seen_in  = 1'b0;
         thru_seen_in = 1'b0;
         rev_in       = 1'b0;
         stop_in      = 1'b0;
         trunc_in     = 1'b0;
         phase_in     = PH_SCAN;
         if (b == 8'd0) begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end else if (phase_ff == PH_SCAN) begin
         pos_in = pos1;
         if (pend_ff != PK_NONE) begin
            unique case (pend_ff)
               PK_WINDOW: begin
                  win_in      = b;
                  win_seen_in = 1'b1;
               end
               PK_PACKET: begin
                  pkt_in      = b;
                  pkt_seen_in = 1'b1;
               end
               PK_THRU: begin
                  thru_in      = b;
                  thru_seen_in = 1'b1;
               end
               PK_CHARGE: begin
                  if (b[0]) begin
                     rev_in = 1'b1;
                  end
                  if (b[1] && pkt_ff == 8'd0) begin
                     pkt_in      = cfg.priority_packet_size;
                     pkt_seen_in = 1'b1;
                  end
               end
               PK_SKIPLEN: ncp_in = pos1_ext + 9'd1 + {1'b0, b};
               default: ;
            endcase
            pend_in = PK_NONE;
         end else if (pos1_ext == ncp_ff && pos1 < len_ff) begin
            if (b == STOP_CODE_LOW || b == STOP_CODE_HIGH) begin
               stop_hit = 1'b1;
               stop_in  = 1'b1;
            end else if (b == cfg.window_code) begin
               pend_in = PK_WINDOW;
               ncp_in  = pos1_ext + 9'd3;
            end else if (b == cfg.packet_code) begin
               pend_in = PK_PACKET;
               ncp_in  = pos1_ext + 9'd3;
            end else if (b == cfg.throughput_code) begin
               pend_in = PK_THRU;
               ncp_in  = pos1_ext + 9'd2;
            end else if (b == cfg.charge_code) begin
               pend_in = PK_CHARGE;
               ncp_in  = pos1_ext + 9'd2;
            end else begin
               case (b[7:6])
                  CLASS_SKIP_ONE:   ncp_in = pos1_ext + 9'd2;
                  CLASS_SKIP_TWO:   ncp_in = pos1_ext + 9'd3;
                  CLASS_SKIP_THREE: ncp_in = pos1_ext + 9'd4;
                  default: begin
                     pend_in = PK_SKIPLEN;
                     ncp_in  = pos1_ext + 9'd2;
                  end
               endcase
            end
         end
         if (stop_hit) begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end else if (pos1 >= len_ff) begin
            if (pend_in != PK_NONE || ncp_in > {1'b0, len_ff} + 9'd1) begin
               trunc_in = 1'b1;
            end
            pend_in  = PK_NONE;
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end
   end

   always_comb begin
      rsp_data_in.window_size     = win_in;
      rsp_data_in.window_seen     = win_seen_in;
      rsp_data_in.packet_size     = pkt_in;
      rsp_data_in.packet_seen     = pkt_seen_in;
      rsp_data_in.throughput      = thru_in;
      rsp_data_in.throughput_seen = thru_seen_in;
      rsp_data_in.reverse_charge  = rev_in;
      rsp_data_in.stopped_early   = stop_in;
      rsp_data_in.truncated       = trunc_in;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         len_ff       <= 8'd0;
         pos_ff       <= 8'd0;
         ncp_ff       <= 9'd0;
         pend_ff      <= PK_NONE;
         win_ff       <= 8'd0;
         pkt_ff       <= 8'd0;
         thru_ff      <= 8'd0;
         win_seen_ff  <= 1'b0;
         pkt_seen_ff  <= 1'b0;
         thru_seen_ff <= 1'b0;
         rev_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         trunc_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff     <= phase_in;
            len_ff       <= len_in;
            pos_ff       <= pos_in;
            ncp_ff       <= ncp_in;
            pend_ff      <= pend_in;
            win_ff       <= win_in;
            pkt_ff       <= pkt_in;
            thru_ff      <= thru_in;
            win_seen_ff  <= win_seen_in;
            pkt_seen_ff  <= pkt_seen_in;
            thru_seen_ff <= thru_seen_in;
            rev_ff       <= rev_in;
            stop_ff      <= stop_in;
            trunc_ff     <= trunc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_chan.payload;
      end
      if (fire && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   a_emit_ends_parse: assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> phase_ff == PH_DONE)
      else $error("parse not closed after result");

   a_no_pending_outside_scan: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SCAN |-> pend_ff == PK_NONE)
      else $error("pending facility outside a field");

   a_pos_within_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SCAN |-> pos_ff < len_ff)
      else $error("scan passed the declared length");

   a_stop_excludes_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.stopped_early && rsp_data_ff.truncated))
      else $error("result both stopped and truncated");

endmodule

// File: design/facility_field_parser_top.sv
// Facility field parser: takes one field byte per req_ transaction, at up to one
// transaction per clock while the rsp_ side does not stall, the length byte marked
// by field_start. Each byte passes an input register and the parse logic; the result
// of a field (collected window, packet size and throughput values with seen flags,
// reverse charge, stop and truncation flags) is registered in the rsp_ output
// register after the byte that ends it: a zero length byte, a stop code, or the byte
// at the declared length. A new length byte drops an unfinished field. Bytes outside
// a field give nothing. Write the csr_ registers only while no field is in flight.
module facility_field_parser_top import ffp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ffp_chan_if.sink   req_chan,
   ffp_chan_if.source rsp_chan,
   ffp_chan_if.sink   csr_chan
);

   ffp_cfg_type cfg;

   ffp_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ffp_parse_core u_parse_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: dv/testbench.sv
module testbench;
   import ffp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ITEMS_PER_PHASE = 190;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned BURST_FIELDS    = 40;
   localparam int unsigned TIMEOUT_NS      = 2000000;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       typed;
      logic       stop;
      logic       trunc;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [28] = '{
      {8'h00,                 1'b1, 1'b1, 1'b0, 1'b0},
      {8'hAA,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h0A,                 1'b1, 1'b0, 1'b0, 1'b0},
      {RESET_WINDOW_CODE,     1'b0, 1'b0, 1'b0, 1'b0},
      {8'hFF,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h00,                 1'b0, 1'b0, 1'b0, 1'b0},
      {RESET_PACKET_CODE,     1'b0, 1'b0, 1'b0, 1'b0},
      {8'h00,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h5A,                 1'b0, 1'b0, 1'b0, 1'b0},
      {RESET_THROUGHPUT_CODE, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'hFF,                 1'b0, 1'b0, 1'b0, 1'b0},
      {RESET_CHARGE_CODE,     1'b0, 1'b0, 1'b0, 1'b0},
      {8'h03,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h03,                 1'b1, 1'b0, 1'b0, 1'b0},
      {STOP_CODE_HIGH,        1'b0, 1'b1, 1'b1, 1'b0},
      {8'h12,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h02,                 1'b1, 1'b0, 1'b0, 1'b0},
      {8'hC5,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h05,                 1'b0, 1'b1, 1'b0, 1'b1},
      {8'h04,                 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h80,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h02,                 1'b1, 1'b0, 1'b0, 1'b0},
      {RESET_WINDOW_CODE,     1'b0, 1'b0, 1'b0, 1'b0},
      {8'h11,                 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h01,                 1'b1, 1'b0, 1'b0, 1'b0},
      {RESET_WINDOW_CODE,     1'b0, 1'b1, 1'b0, 1'b0},
      {8'hFF,                 1'b1, 1'b0, 1'b0, 1'b0},
      {STOP_CODE_LOW,         1'b0, 1'b1, 1'b1, 1'b0}
   };

   localparam ffp_cfg_type CODE_SETTINGS [6] = '{
      {RESET_WINDOW_CODE, RESET_PACKET_CODE, RESET_THROUGHPUT_CODE, RESET_CHARGE_CODE,
       RESET_PRIORITY_SIZE},
      {8'd1,   8'd254, 8'd127, 8'd200, 8'd0},
      {8'd254, 8'd1,   8'd64,  8'd3,   8'd255},
      {8'd5,   8'd5,   8'd5,   8'd5,   8'd99},
      {8'd0,   8'd255, 8'd2,   8'd2,   8'd128},
      {8'd192, 8'd128, 8'd66,  8'd67,  8'd1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffp_chan_if #(.payload_type(ffp_req_type)) req_chan ();
   ffp_chan_if #(.payload_type(ffp_rsp_type)) rsp_chan ();
   ffp_chan_if #(.payload_type(ffp_csr_type)) csr_chan ();

   facility_field_parser_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   ffp_cfg_type   code_regs;
   ffp_phase_type scan_phase;
   ffp_pend_type  awaited_value;
   logic [7:0]    field_len;
   logic [9:0]    byte_pos;
   logic [9:0]    code_pos;
   ffp_rsp_type   options;

   ffp_rsp_type   pending_options [$];
   int unsigned   error_count = 0;
   bit            req_idle = 1'b1;
   bit            rsp_idle = 1'b1;
   bit            hold_req = 1'b0;

   function automatic void reset_parser();
      code_regs     = {RESET_WINDOW_CODE, RESET_PACKET_CODE, RESET_THROUGHPUT_CODE,
                       RESET_CHARGE_CODE, RESET_PRIORITY_SIZE};
      scan_phase    = PH_IDLE;
      awaited_value = PK_NONE;
      field_len     = '0;
      byte_pos      = '0;
      code_pos      = '0;
      options       = '0;
   endfunction

   function automatic bit parse_facility_byte(input ffp_req_type item, output ffp_rsp_type res);
      logic [7:0] b;
      logic [9:0] pos;
      b   = item.data_byte;
      res = '0;
      if (item.field_start) begin
         field_len     = b;
         byte_pos      = '0;
         code_pos      = 10'd1;
         awaited_value = PK_NONE;
         options       = '0;
         scan_phase    = PH_SCAN;
         if (b == 8'd0) begin
            scan_phase = PH_DONE;
            res        = options;
            return 1'b1;
         end
         return 1'b0;
      end
      if (scan_phase != PH_SCAN) return 1'b0;

      byte_pos = byte_pos + 10'd1;
      pos      = byte_pos;

      if (awaited_value != PK_NONE) begin
         case (awaited_value)
            PK_WINDOW: begin
               options.window_size = b;
               options.window_seen = 1'b1;
            end
            PK_PACKET: begin
               options.packet_size = b;
               options.packet_seen = 1'b1;
            end
            PK_THRU: begin
               options.throughput      = b;
               options.throughput_seen = 1'b1;
            end
            PK_CHARGE: begin
               if (b[0]) options.reverse_charge = 1'b1;
               if (b[1] && options.packet_size == 8'd0) begin
                  options.packet_size = code_regs.priority_packet_size;
                  options.packet_seen = 1'b1;
               end
            end
            PK_SKIPLEN: code_pos = pos + 10'd1 + {2'b00, b};
            default: ;
         endcase
         awaited_value = PK_NONE;
      end else if (pos == code_pos && pos < {2'b00, field_len}) begin
         if (b == STOP_CODE_LOW || b == STOP_CODE_HIGH) begin
            options.stopped_early = 1'b1;
            scan_phase            = PH_DONE;
            res                   = options;
            return 1'b1;
         end
         if (b == code_regs.window_code) begin
            awaited_value = PK_WINDOW;
            code_pos      = pos + 10'd3;
         end else if (b == code_regs.packet_code) begin
            awaited_value = PK_PACKET;
            code_pos      = pos + 10'd3;
         end else if (b == code_regs.throughput_code) begin
            awaited_value = PK_THRU;
            code_pos      = pos + 10'd2;
         end else if (b == code_regs.charge_code) begin
            awaited_value = PK_CHARGE;
            code_pos      = pos + 10'd2;
         end else begin
            case (b[7:6])
               CLASS_SKIP_ONE:   code_pos = pos + 10'd2;
               CLASS_SKIP_TWO:   code_pos = pos + 10'd3;
               CLASS_SKIP_THREE: code_pos = pos + 10'd4;
               default: begin
                  awaited_value = PK_SKIPLEN;
                  code_pos      = pos + 10'd2;
               end
            endcase
         end
      end

      if (pos >= {2'b00, field_len}) begin
         if (awaited_value != PK_NONE || code_pos > {2'b00, field_len} + 10'd1)
            options.truncated = 1'b1;
         awaited_value = PK_NONE;
         scan_phase    = PH_DONE;
         res           = options;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%02h, expected 0x%02h", field, got, want));
   endtask

   task automatic check_options(input ffp_rsp_type got, input ffp_rsp_type want);
      check_field("window_size", got.window_size, want.window_size);
      check_field("window_seen", 8'(got.window_seen), 8'(want.window_seen));
      check_field("packet_size", got.packet_size, want.packet_size);
      check_field("packet_seen", 8'(got.packet_seen), 8'(want.packet_seen));
      check_field("throughput", got.throughput, want.throughput);
      check_field("throughput_seen", 8'(got.throughput_seen), 8'(want.throughput_seen));
      check_field("reverse_charge", 8'(got.reverse_charge), 8'(want.reverse_charge));
      check_field("stopped_early", 8'(got.stopped_early), 8'(want.stopped_early));
      check_field("truncated", 8'(got.truncated), 8'(want.truncated));
   endtask

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic start,
                            input bit use_typed = 1'b0, input ffp_rsp_type typed_rsp = '0);
      int unsigned gap;
      ffp_rsp_type predicted;
      gap = pick_gap(req_idle);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= ffp_req_type'({data, start});
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (parse_facility_byte(ffp_req_type'({data, start}), predicted))
         pending_options.push_back(use_typed ? typed_rsp : predicted);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_chan.valid   <= 1'b1;
      csr_chan.payload <= ffp_csr_type'({idx, value});
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_CODE:     code_regs.window_code          = value;
         CSR_PACKET_CODE:     code_regs.packet_code          = value;
         CSR_THROUGHPUT_CODE: code_regs.throughput_code      = value;
         CSR_CHARGE_CODE:     code_regs.charge_code          = value;
         CSR_PRIORITY_SIZE:   code_regs.priority_packet_size = value;
         default: ;
      endcase
   endtask

   task automatic load_codes(input ffp_cfg_type setting);
      write_reg(CSR_WINDOW_CODE, setting.window_code);
      write_reg(CSR_PACKET_CODE, setting.packet_code);
      write_reg(CSR_THROUGHPUT_CODE, setting.throughput_code);
      write_reg(CSR_CHARGE_CODE, setting.charge_code);
      write_reg(CSR_PRIORITY_SIZE, setting.priority_packet_size);
      csr_chan.valid <= 1'b0;
   endtask

   // close any open field, then wait for every result and let the pipeline settle
   task automatic drain_fields();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      if (scan_phase == PH_SCAN) begin
         send_byte(8'h00, 1'b1);
         req_chan.valid <= 1'b0;
      end
      while (pending_options.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_field(inout int unsigned sent);
      logic [7:0]  body [$];
      int unsigned len;
      int unsigned r;
      int unsigned n;
      int unsigned keep;
      int unsigned i;
      r = $urandom_range(0, 99);
      if (r < 4) len = 0;
      else if (r < 6) len = 255;
      else if (r < 9) len = $urandom_range(100, 254);
      else len = $urandom_range(1, 24);

      while (body.size() < len) begin
         case ($urandom_range(0, 15))
            0, 1: begin
               body.push_back(code_regs.window_code);
               body.push_back(8'($urandom));
               body.push_back(8'($urandom));
            end
            2, 3: begin
               body.push_back(code_regs.packet_code);
               body.push_back(8'($urandom));
               body.push_back(8'($urandom));
            end
            4, 5: begin
               body.push_back(code_regs.throughput_code);
               body.push_back(8'($urandom));
            end
            6, 7: begin
               body.push_back(code_regs.charge_code);
               body.push_back(8'($urandom));
            end
            8, 9: begin
               body.push_back({CLASS_SKIP_ONE, 6'($urandom)});
               body.push_back(8'($urandom));
            end
            10: begin
               body.push_back({CLASS_SKIP_TWO, 6'($urandom)});
               repeat (2) body.push_back(8'($urandom));
            end
            11: begin
               body.push_back({CLASS_SKIP_THREE, 6'($urandom)});
               repeat (3) body.push_back(8'($urandom));
            end
            12, 13: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
               body.push_back({2'b11, 6'($urandom)});
               body.push_back(8'(n));
               repeat (n) body.push_back(8'($urandom));
            end
            14: begin
               if ($urandom_range(0, 2) == 0)
                  body.push_back($urandom_range(0, 1) ? STOP_CODE_HIGH : STOP_CODE_LOW);
               else
                  body.push_back(8'($urandom));
            end
            default: body.push_back(8'($urandom));
         endcase
      end

      keep = len;
      r    = $urandom_range(0, 99);
      if (r < 8 && len > 0) keep = $urandom_range(0, len - 1);
      send_byte(8'(len), 1'b1);
      for (i = 0; i < keep; i++) send_byte(body[i], 1'b0);
      sent += keep + 1;
      if (r >= 90) repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic run_random(input int unsigned budget);
      int unsigned sent;
      sent = 0;
      while (sent < budget) send_random_field(sent);
   endtask

   initial begin
      ffp_rsp_type typed_rsp;
      ffp_cfg_type setting;
      int unsigned phase;
      bit          saved_idle;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.payload <= '0;
      reset_parser();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         typed_rsp               = '0;
         typed_rsp.stopped_early = DIRECTED_ROWS[i].stop;
         typed_rsp.truncated     = DIRECTED_ROWS[i].trunc;
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].typed,
                   typed_rsp);
      end
      run_random(ITEMS_PER_PHASE);

      for (phase = 0; phase < 7; phase++) begin
         drain_fields();
         if (phase < 6)
            setting = CODE_SETTINGS[phase];
         else
            setting = ffp_cfg_type'({8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
                                     8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
                                     8'($urandom)});
         load_codes(setting);
         req_idle = (phase % 3) != 1;
         rsp_idle = (phase % 3) != 2;
         if (phase == 2) begin
            // stall the result side and flood with empty fields
            hold_req = 1'b1;
            while (hold_req) @(posedge clock);
            saved_idle = req_idle;
            req_idle   = 1'b0;
            repeat (BURST_FIELDS) send_byte(8'h00, 1'b1);
            req_idle = saved_idle;
         end
         run_random(ITEMS_PER_PHASE);
      end
      drain_fields();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = pick_gap(rsp_idle);
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_options.size() == 0)
            report_mismatch("result transaction with no field result pending");
         else
            check_options(rsp_chan.payload, pending_options.pop_front());
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
